[hdl/jcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_pkg
// Shared types and character codes for the comment stripper.
// ----------------------------------------------------------------------------
package jcs_pkg;

  // Scan modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_STRING = 2'd1;
  localparam logic [1:0] MODE_LINE   = 2'd2;
  localparam logic [1:0] MODE_BLOCK  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Reported field width
  localparam int REPORT_BITS = 24;

  // One result word
  typedef struct packed {
    logic [7:0]             clean_byte;
    logic                   newline_seen;
    logic [REPORT_BITS-1:0] newline_position;
    logic [REPORT_BITS-1:0] newline_number;
    logic                   open_comment_error;
    logic                   last_out;
  } result_t;

endpackage

[hdl/json_comment_stripper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_comment_stripper
// Replaces // and /* */ comments in a byte stream with spaces and reports
// every newline with its offset and running number.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one text byte per word with
//   final_byte marking the end of a text. Output channel (out_valid /
//   out_stall) returns the cleaned bytes plus newline info; last_out marks
//   the final word of a text and open_comment_error is raised there when a
//   block comment was left open.
// A '/' in normal text is held until the next byte decides whether a
//   comment opens; that byte then yields two words (the held '/' or its
//   space, then the byte or its space).
// Throughput: one byte per cycle while the output queue has room (in_stall low).
//   Results go into a four-word output queue; input is stalled whenever the
//   queue could not take two more words, so a slow receiver only stalls the
//   sender and no word is lost.
// Reset (rst, synchronous, active high): normal mode, nothing held,
//   position and newline counters cleared, output queue emptied. The same
//   scan state returns after each text's final byte.
// Position and newline count saturate at 2^POSITION_BITS-1; reported values
//   are the low 24 bits.
// ----------------------------------------------------------------------------
module json_comment_stripper #(
  parameter int POSITION_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   text_byte,
  input  logic                         final_byte,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   clean_byte,
  output logic                         newline_seen,
  output logic [jcs_pkg::REPORT_BITS-1:0] newline_position,
  output logic [jcs_pkg::REPORT_BITS-1:0] newline_number,
  output logic                         open_comment_error,
  output logic                         last_out
);
  import jcs_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // Scan state
  logic [1:0]               scan_mode, scan_mode_next;
  logic [7:0]               held_byte, held_byte_next;
  logic                     held_valid, held_valid_next;
  logic                     star_prev, star_prev_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] newline_total, newline_total_next;

  // Output queue
  result_t    queue [4];
  logic [1:0] head, tail;
  logic [2:0] count;

  logic       accept, pop;
  logic [1:0] push_n;
  result_t    res0, res1;

  // Step logic
  logic       have_held, done, emit, nl, err;
  logic [7:0] cb, held_cb;
  result_t    main_res, held_res;

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;
  // room for two words without counting this cycle's pop
  assign in_stall = (count > 3'd2);

  always_comb begin
    scan_mode_next     = scan_mode;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    star_prev_next     = star_prev;
    done               = 1'b0;
    emit               = 1'b1;
    nl                 = 1'b0;
    cb                 = text_byte;
    held_cb            = held_byte;
    have_held          = (scan_mode == MODE_NORMAL) && held_valid;

    // resolve a held slash
    if (have_held) begin
      held_valid_next = 1'b0;
      held_byte_next  = 8'd0;
      if (text_byte == CH_SLASH) begin
        held_cb        = CH_SPACE;
        cb             = CH_SPACE;
        scan_mode_next = MODE_LINE;
        done           = 1'b1;
      end else if (text_byte == CH_STAR) begin
        held_cb        = CH_SPACE;
        cb             = CH_SPACE;
        scan_mode_next = MODE_BLOCK;
        star_prev_next = 1'b1;   // opening star counts toward "*/"
        done           = 1'b1;
      end
    end

    if (!done) begin
      unique case (scan_mode)
        MODE_NORMAL: begin
          if (text_byte == CH_NL) begin
            nl = 1'b1;
          end else if (text_byte == CH_QUOTE) begin
            scan_mode_next = MODE_STRING;
          end else if (text_byte == CH_SLASH && !final_byte) begin
            held_byte_next  = text_byte;
            held_valid_next = 1'b1;
            emit            = 1'b0;
          end
        end
        MODE_STRING: begin
          if (text_byte == CH_NL) begin
            nl = 1'b1;
          end else if (text_byte == CH_QUOTE) begin
            scan_mode_next = MODE_NORMAL;
          end
        end
        MODE_LINE: begin
          if (text_byte == CH_NL) begin
            nl             = 1'b1;
            scan_mode_next = MODE_NORMAL;
          end else begin
            cb = CH_SPACE;
          end
        end
        MODE_BLOCK: begin
          if (text_byte == CH_NL) begin
            nl             = 1'b1;
            star_prev_next = 1'b0;
          end else begin
            cb = CH_SPACE;
            if (text_byte == CH_SLASH && star_prev) begin
              scan_mode_next = MODE_NORMAL;
              star_prev_next = 1'b0;
            end else begin
              star_prev_next = (text_byte == CH_STAR);
            end
          end
        end
        default: begin
          scan_mode_next = MODE_NORMAL;
        end
      endcase
    end

    newline_total_next = (nl && newline_total != POS_MAX) ?
                         newline_total + 1'b1 : newline_total;
    byte_position_next = (byte_position != POS_MAX) ?
                         byte_position + 1'b1 : byte_position;

    err = final_byte && (scan_mode_next == MODE_BLOCK);

    main_res.clean_byte         = cb;
    main_res.newline_seen       = nl;
    main_res.newline_position   = nl ? REPORT_BITS'(32'(byte_position)) : '0;
    main_res.newline_number     = nl ? REPORT_BITS'(32'(newline_total_next)) : '0;
    main_res.open_comment_error = err;
    main_res.last_out           = final_byte;

    held_res.clean_byte         = held_cb;
    held_res.newline_seen       = 1'b0;
    held_res.newline_position   = '0;
    held_res.newline_number     = '0;
    held_res.open_comment_error = 1'b0;
    held_res.last_out           = 1'b0;

    // the held word always goes first
    res0   = have_held ? held_res : main_res;
    res1   = main_res;
    push_n = {1'b0, have_held} + {1'b0, emit};

    // end of text: scan state back to reset values
    if (final_byte) begin
      scan_mode_next     = MODE_NORMAL;
      held_byte_next     = 8'd0;
      held_valid_next    = 1'b0;
      star_prev_next     = 1'b0;
      byte_position_next = '0;
      newline_total_next = '0;
    end
  end

  // Scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_NORMAL;
      held_byte     <= 8'd0;
      held_valid    <= 1'b0;
      star_prev     <= 1'b0;
      byte_position <= '0;
      newline_total <= '0;
    end else if (accept) begin
      scan_mode     <= scan_mode_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      star_prev     <= star_prev_next;
      byte_position <= byte_position_next;
      newline_total <= newline_total_next;
    end
  end

  // Output queue storage (payload, no reset)
  always_ff @(posedge clk) begin
    if (accept && push_n != 2'd0) begin
      queue[tail] <= res0;
    end
    if (accept && push_n == 2'd2) begin
      queue[tail + 2'd1] <= res1;
    end
  end

  // Output queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      tail  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (accept) begin
        tail <= tail + push_n;
      end
      if (pop) begin
        head <= head + 2'd1;
      end
      count <= count + (accept ? {1'b0, push_n} : 3'd0) - {2'b0, pop};
    end
  end

  assign out_valid          = (count != 3'd0);
  assign clean_byte         = queue[head].clean_byte;
  assign newline_seen       = queue[head].newline_seen;
  assign newline_position   = queue[head].newline_position;
  assign newline_number     = queue[head].newline_number;
  assign open_comment_error = queue[head].open_comment_error;
  assign last_out           = queue[head].last_out;

endmodule
